>>> sv/positional_list_insert_delete_defines.svh
// Assertion macros shared by the positional list design.
`ifndef POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PLID_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("positional list assertion failed (same cycle)");

// Checks that the consequent holds in the cycle after the antecedent.
`define PLID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("positional list assertion failed (next cycle)");

`endif

>>> sv/plid_pkg.sv
// Package with command, status and cell select codes of the positional list.
`default_nettype none
package plid_pkg;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_AT    = 3'd5,
        CMD_DUMP      = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_BADPOS = 2'd1,
        STS_FULL   = 2'd2,
        STS_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        SEL_HOLD,
        SEL_LOAD,
        SEL_LEFT,
        SEL_RIGHT,
        SEL_HEAD
    } t_cell_sel;

endpackage
`default_nettype wire

>>> sv/plid_cell.sv
// One storage cell of the list chain, loading from the input, a neighbor or the head cell.
`default_nettype none
module plid_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                  i_clk,
    input  plid_pkg::t_cell_sel  i_sel,
    input  wire [DATA_WIDTH-1:0] i_value,
    input  wire [DATA_WIDTH-1:0] i_left,
    input  wire [DATA_WIDTH-1:0] i_right,
    input  wire [DATA_WIDTH-1:0] i_head,
    output logic [DATA_WIDTH-1:0] o_data
);
    import plid_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        case (i_sel)
            SEL_HOLD:  n_data = r_data;
            SEL_LOAD:  n_data = i_value;
            SEL_LEFT:  n_data = i_left;
            SEL_RIGHT: n_data = i_right;
            SEL_HEAD:  n_data = i_head;
            default:   n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

>>> sv/positional_list_insert_delete.sv
// Top level of the positional list: control, length register and cell chain.
// Insert and delete commands give their registered result in the cycle after start.
// A dump of N elements moves to the dump state on start, then registers N results, one per cycle,
// set by the rotation of the cell chain; busy is high while in the dump state.
// Any command may start in the cycle that shows the previous result.
// Synchronous active-low reset empties the list; the receiver cannot stall.
`default_nettype none
`include "positional_list_insert_delete_defines.svh"
module positional_list_insert_delete #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  wire  [2:0]        i_command,
    input  wire signed [31:0] i_value,
    input  wire  [7:0]        i_position,
    output logic              o_strobe,
    output logic [1:0]        o_status,
    output logic signed [31:0] o_element,
    output logic              o_has_element,
    output logic [4:0]        o_count,
    output logic              o_last
);
    import plid_pkg::*;

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

    t_state               r_state;
    logic [LEN_W-1:0]     r_length;
    logic [IDX_W-1:0]     r_dump_cnt;
    logic                 r_strobe;
    t_status              r_status;
    logic [31:0]          r_element;
    logic                 r_has_element;
    logic [4:0]           r_count;
    logic                 r_last;

    logic [LEN_W-1:0]     n_length;
    t_status              n_status;

    logic                 w_accept;
    logic                 w_do_ins;
    logic                 w_do_del;
    logic                 w_do_rot;
    logic [LEN_W-1:0]     w_idx;
    logic [LEN_W-1:0]     w_tail;
    logic [8:0]           w_pos;
    logic [8:0]           w_len;
    logic                 w_full;
    logic                 w_empty;
    logic [DATA_WIDTH-1:0] w_value;
    t_cell_sel            w_sel  [CAPACITY];
    logic [DATA_WIDTH-1:0] w_data [CAPACITY];

    assign w_accept = start && !busy;
    assign w_pos    = {1'b0, i_position};
    assign w_len    = 9'(r_length);
    assign w_full   = (r_length == LEN_W'(CAPACITY));
    assign w_empty  = (r_length == '0);
    assign w_tail   = r_length - 1'b1;
    assign w_value  = DATA_WIDTH'($unsigned(i_value));
    assign w_do_rot = (r_state == ST_DUMP);

    always_comb begin
        w_do_ins = 1'b0;
        w_do_del = 1'b0;
        w_idx    = '0;
        n_status = STS_OK;
        n_length = r_length;
        case (t_cmd'(i_command))
            CMD_INS_FRONT, CMD_INS_BACK: begin
                if (w_full) begin
                    n_status = STS_FULL;
                end else begin
                    w_do_ins = w_accept;
                    w_idx    = (t_cmd'(i_command) == CMD_INS_FRONT) ? '0 : r_length;
                end
            end
            CMD_INS_AT: begin
                if (w_pos == 9'd0 || w_pos > w_len + 9'd1) begin
                    n_status = STS_BADPOS;
                end else if (w_full) begin
                    n_status = STS_FULL;
                end else begin
                    w_do_ins = w_accept;
                    w_idx    = LEN_W'(w_pos - 9'd1);
                end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK: begin
                if (w_empty) begin
                    n_status = STS_EMPTY;
                end else begin
                    w_do_del = w_accept;
                    w_idx    = (t_cmd'(i_command) == CMD_DEL_FRONT) ? '0 : w_tail;
                end
            end
            CMD_DEL_AT: begin
                if (w_pos == 9'd0 || w_pos > w_len) begin
                    n_status = STS_BADPOS;
                end else begin
                    w_do_del = w_accept;
                    w_idx    = LEN_W'(w_pos - 9'd1);
                end
            end
            CMD_DUMP: begin
                n_status = w_empty ? STS_EMPTY : STS_OK;
            end
            default: begin
                n_status = STS_BADPOS;
            end
        endcase
        if (w_do_ins) begin
            n_length = r_length + 1'b1;
        end else if (w_do_del) begin
            n_length = w_tail;
        end
    end

    always_comb begin
        for (int c = 0; c < CAPACITY; c++) begin
            w_sel[c] = SEL_HOLD;
            if (w_do_rot) begin
                if (LEN_W'(c) < w_tail) begin
                    w_sel[c] = SEL_RIGHT;
                end else if (LEN_W'(c) == w_tail) begin
                    w_sel[c] = SEL_HEAD;
                end
            end else if (w_do_ins) begin
                if (LEN_W'(c) == w_idx) begin
                    w_sel[c] = SEL_LOAD;
                end else if (LEN_W'(c) > w_idx) begin
                    w_sel[c] = SEL_LEFT;
                end
            end else if (w_do_del) begin
                if (LEN_W'(c) >= w_idx && c < CAPACITY - 1) begin
                    w_sel[c] = SEL_RIGHT;
                end
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        plid_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_sel   (w_sel[g]),
            .i_value (w_value),
            .i_left  ((g == 0) ? '0 : w_data[(g == 0) ? 0 : g - 1]),
            .i_right ((g == CAPACITY - 1) ? '0 : w_data[(g == CAPACITY - 1) ? g : g + 1]),
            .i_head  (w_data[0]),
            .o_data  (w_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_length   <= '0;
            r_dump_cnt <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (t_cmd'(i_command) == CMD_DUMP && !w_empty) begin
                            r_state    <= ST_DUMP;
                            r_dump_cnt <= '0;
                        end else begin
                            r_length      <= n_length;
                            r_strobe      <= 1'b1;
                            r_status      <= n_status;
                            r_element     <= '0;
                            r_has_element <= 1'b0;
                            r_count       <= 5'(n_length);
                            r_last        <= 1'b1;
                        end
                    end
                end
                ST_DUMP: begin
                    r_strobe      <= 1'b1;
                    r_status      <= STS_OK;
                    r_element     <= 32'(w_data[0]);
                    r_has_element <= 1'b1;
                    r_count       <= 5'(r_length);
                    r_dump_cnt    <= r_dump_cnt + 1'b1;
                    if (r_dump_cnt == IDX_W'(w_tail)) begin
                        r_last  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_last <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state == ST_DUMP);
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_element     = r_element;
    assign o_has_element = r_has_element;
    assign o_count       = r_count;
    assign o_last        = r_last;

    `PLID_ASSERT_NEXT(a_dump_burst, i_clk, i_rst_n, o_strobe && !o_last, o_strobe)
    `PLID_ASSERT_NOW(a_dump_nonempty, i_clk, i_rst_n, busy, r_length != '0)
    `PLID_ASSERT_NOW(a_len_bound, i_clk, i_rst_n, 1'b1, r_length <= LEN_W'(CAPACITY))
    `PLID_ASSERT_NEXT(a_accept_reply, i_clk, i_rst_n, start && !busy, o_strobe || busy)

endmodule
`default_nettype wire
